/* design/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared widths and codes for the polynomial fold reduction block.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_DEGREE = 4096;
    localparam int COEFF_BITS = 32;
    localparam int IDX_BITS   = $clog2(MAX_DEGREE);
    localparam int DEG_BITS   = 13;
    localparam int CNT_BITS   = 13;
    localparam int STEP_BITS  = $clog2(COEFF_BITS);

    typedef logic [COEFF_BITS-1:0] t_coeff;

    // configuration register indexes
    localparam logic [1:0] CFG_FOLD_DEGREE   = 2'd0;
    localparam logic [1:0] CFG_CONST_TERM    = 2'd1;
    localparam logic [1:0] CFG_PRIME_MODULUS = 2'd2;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

endpackage

/* design/pfr_mulmod.sv */
// ----------------------------------------------------------------------------
// pfr_mulmod
// Bit-serial modular multiply: (a * b) mod p, one bit of b per cycle.
// a must be below p; b may be any value.
// ----------------------------------------------------------------------------
module pfr_mulmod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pfr_pkg::t_coeff      i_a,
    input  pfr_pkg::t_coeff      i_b,
    input  pfr_pkg::t_coeff      i_p,
    output logic                 o_done,
    output pfr_pkg::t_coeff      o_res
);
    import pfr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    t_coeff               r_acc;
    t_coeff               r_a;
    t_coeff               r_b;
    t_coeff               r_p;

    logic [COEFF_BITS:0]  w_dbl;
    logic [COEFF_BITS:0]  w_dbl_r;
    logic [COEFF_BITS:0]  w_sum;
    logic [COEFF_BITS:0]  w_sum_r;

    // one double-and-add step
    always_comb begin
        w_dbl   = {r_acc, 1'b0};
        w_dbl_r = (w_dbl >= {1'b0, r_p}) ? w_dbl - {1'b0, r_p} : w_dbl;
        w_sum   = w_dbl_r + (r_b[COEFF_BITS-1] ? {1'b0, r_a} : '0);
        w_sum_r = (w_sum >= {1'b0, r_p}) ? w_sum - {1'b0, r_p} : w_sum;
    end

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= i_p;
            r_b <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[COEFF_BITS-2:0], 1'b0};
            r_acc <= w_sum_r[COEFF_BITS-1:0];
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(COEFF_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

/* design/poly_fold_reduce_mod_xm_plus_r.sv */
// ----------------------------------------------------------------------------
// poly_fold_reduce_mod_xm_plus_r
// Streaming fold of a polynomial modulo x^m + r over the integers mod p.
// ----------------------------------------------------------------------------
// Coefficients pushed lowest degree first are folded into a 4096-entry
// accumulator memory (one read, one write port, registered read); coefficient
// k*m+j adds (-r)^k * c into entry j. Every multiply and reduction mod p runs
// through one bit-serial multiplier doing 32 steps per pass; additions and
// negation mod p are done beside it. A push takes three passes (reduce c,
// multiply by block factor, reduce the old entry) and a write, or two passes
// and the write when the entry is fresh in this polynomial. Each time a block
// of m coefficients closes two more passes follow. A read goes through a
// memory read state and a data state, then one reduction pass; a read outside
// the received range answers 0 in the cycle after acceptance. One transaction
// is worked on at a time and a waiting result holds off the next one. Entries
// of an earlier polynomial are ignored through a fill mark, so no clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module poly_fold_reduce_mod_xm_plus_r (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] coeff_in, [43:32] read_index
    input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] start_poly
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] coeff_out
);
    import pfr_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLOSE_R = 4'd1;
    localparam logic [3:0] ST_CLOSE_M = 4'd2;
    localparam logic [3:0] ST_C_RED   = 4'd3;
    localparam logic [3:0] ST_PROD    = 4'd4;
    localparam logic [3:0] ST_OLD_RED = 4'd5;
    localparam logic [3:0] ST_WRITE   = 4'd6;
    localparam logic [3:0] ST_RD_MEM  = 4'd7;
    localparam logic [3:0] ST_RD_RED  = 4'd8;
    localparam logic [3:0] ST_RD_DATA = 4'd9;

    // configuration registers
    logic [DEG_BITS-1:0] r_fold_degree;
    t_coeff              r_const_term;
    t_coeff              r_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_degree <= DEG_BITS'(2048);
            r_const_term  <= COEFF_BITS'(1);
            r_prime       <= COEFF_BITS'(64'd4294967291);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FOLD_DEGREE:   r_fold_degree <= i_cfg_wdata[DEG_BITS-1:0];
                CFG_CONST_TERM:    r_const_term  <= i_cfg_wdata;
                CFG_PRIME_MODULUS: r_prime       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective modulus and degree
    t_coeff              w_p;
    t_coeff              w_one;
    logic [DEG_BITS-1:0] w_m;

    always_comb begin
        w_p   = (r_prime < COEFF_BITS'(2)) ? COEFF_BITS'(1) : r_prime;
        w_one = (w_p == COEFF_BITS'(1)) ? '0 : COEFF_BITS'(1);
        if (r_fold_degree == '0) begin
            w_m = DEG_BITS'(1);
        end else if (r_fold_degree > DEG_BITS'(MAX_DEGREE)) begin
            w_m = DEG_BITS'(MAX_DEGREE);
        end else begin
            w_m = r_fold_degree;
        end
    end

    // request fields
    logic                w_req_type;
    logic                w_start_poly;
    t_coeff              w_coeff_in;
    logic [IDX_BITS-1:0] w_read_index;

    assign w_req_type   = s_axis_tuser[0];
    assign w_start_poly = s_axis_tuser[1];
    assign w_coeff_in   = s_axis_tdata[31:0];
    assign w_read_index = s_axis_tdata[32 +: IDX_BITS];

    // control and state registers
    logic [3:0]          r_state;
    logic [DEG_BITS-1:0] r_pos;
    logic [CNT_BITS-1:0] r_count;
    logic [DEG_BITS-1:0] r_fill;
    t_coeff              r_factor;
    t_coeff              r_coeff;
    t_coeff              r_tmp;
    t_coeff              r_prod;
    logic [IDX_BITS-1:0] r_rd_idx;
    logic                r_after;
    logic                r_out_valid;
    t_coeff              r_out_data;

    // serial multiplier
    logic   r_go;
    t_coeff r_op_a;
    t_coeff r_op_b;
    logic   w_done;
    t_coeff w_res;

    pfr_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (r_op_a),
        .i_b     (r_op_b),
        .i_p     (w_p),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // accumulator memory
    t_coeff              mem_acc [MAX_DEGREE];
    t_coeff              r_mem_q;
    logic [IDX_BITS-1:0] w_rd_addr;
    logic                w_mem_we;
    t_coeff              w_new_acc;
    logic [COEFF_BITS:0] w_sum;

    assign w_rd_addr = (r_state == ST_RD_MEM) ? r_rd_idx : r_pos[IDX_BITS-1:0];
    assign w_mem_we  = (r_state == ST_WRITE);

    always_comb begin
        w_sum     = {1'b0, r_tmp} + {1'b0, r_prod};
        w_new_acc = (w_sum >= {1'b0, w_p}) ? COEFF_BITS'(w_sum - {1'b0, w_p})
                                           : w_sum[COEFF_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_acc[r_pos[IDX_BITS-1:0]] <= w_new_acc;
        end
        r_mem_q <= mem_acc[w_rd_addr];
    end

    // handshake
    logic w_accept;
    logic w_rd_ok;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_rd_ok = ({1'b0, w_read_index} < w_m)
                  && ({1'b0, w_read_index} < r_count)
                  && ({1'b0, w_read_index} < r_fill);

    logic [DEG_BITS-1:0] w_pos_inc;
    assign w_pos_inc = r_pos + 1'b1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_factor    <= COEFF_BITS'(1);
            r_after     <= 1'b0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_req_type == REQ_READ) begin
                            if (w_rd_ok) begin
                                r_rd_idx <= w_read_index;
                                r_state  <= ST_RD_MEM;
                            end else begin
                                r_out_data  <= '0;
                                r_out_valid <= 1'b1;
                            end
                        end else begin
                            r_coeff <= w_coeff_in;
                            r_go    <= 1'b1;
                            if (w_start_poly || r_pos < w_m) begin
                                if (w_start_poly) begin
                                    r_pos    <= '0;
                                    r_count  <= '0;
                                    r_fill   <= '0;
                                    r_factor <= COEFF_BITS'(1);
                                end
                                r_op_a  <= w_one;
                                r_op_b  <= w_coeff_in;
                                r_state <= ST_C_RED;
                            end else begin
                                r_after <= 1'b0;
                                r_op_a  <= w_one;
                                r_op_b  <= r_const_term;
                                r_state <= ST_CLOSE_R;
                            end
                        end
                    end
                end
                ST_CLOSE_R: begin
                    if (w_done) begin
                        r_op_a  <= w_res;
                        r_op_b  <= r_factor;
                        r_go    <= 1'b1;
                        r_state <= ST_CLOSE_M;
                    end
                end
                ST_CLOSE_M: begin
                    if (w_done) begin
                        r_factor <= (w_res == '0) ? '0 : w_p - w_res;
                        r_pos    <= '0;
                        if (r_after) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_op_a  <= w_one;
                            r_op_b  <= r_coeff;
                            r_go    <= 1'b1;
                            r_state <= ST_C_RED;
                        end
                    end
                end
                ST_C_RED: begin
                    if (w_done) begin
                        r_op_a  <= w_res;
                        r_op_b  <= r_factor;
                        r_go    <= 1'b1;
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    if (w_done) begin
                        r_prod <= w_res;
                        if (r_pos < r_fill) begin
                            r_op_a  <= w_one;
                            r_op_b  <= r_mem_q;
                            r_go    <= 1'b1;
                            r_state <= ST_OLD_RED;
                        end else begin
                            r_tmp   <= '0;
                            r_state <= ST_WRITE;
                        end
                    end
                end
                ST_OLD_RED: begin
                    if (w_done) begin
                        r_tmp   <= w_res;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (r_pos >= r_fill) begin
                        r_fill <= w_pos_inc;
                    end
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_pos <= w_pos_inc;
                    if (w_pos_inc >= w_m) begin
                        r_after <= 1'b1;
                        r_op_a  <= w_one;
                        r_op_b  <= r_const_term;
                        r_go    <= 1'b1;
                        r_state <= ST_CLOSE_R;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                // memory read of the requested entry in flight
                ST_RD_MEM: begin
                    r_state <= ST_RD_DATA;
                end
                // registered read data available, reduce it
                ST_RD_DATA: begin
                    r_state <= ST_RD_RED;
                    r_go    <= 1'b1;
                    r_op_a  <= w_one;
                    r_op_b  <= r_mem_q;
                end
                ST_RD_RED: begin
                    if (w_done) begin
                        r_out_data  <= w_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
